// ----- design/msfof_pkg.sv -----
// Shared types, character codes and sizes for the Mode S frame output formatter.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package msfof_pkg;

  localparam logic [7:0] ESC_BYTE   = 8'h1a;
  localparam logic [7:0] CHAR_STAR  = 8'h2a;
  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_SEMI  = 8'h3b;
  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_THREE = 8'h33;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A_OFS = 8'h37;
  localparam logic [7:0] LEVEL_MAX  = 8'hff;

  localparam logic [3:0] SHORT_FRAME_LEN = 4'd7;

  localparam int TS_W       = 48;
  localparam int TS_NIBBLES = 12;
  localparam int TS_BYTES   = 6;
  localparam int CNT_W      = 4;

  localparam int          SQRT_W         = 14;
  localparam int          SQRT_BIT_W     = 13;
  localparam int          ROOT_W         = 7;
  localparam logic [31:0] SQRT_SAT_POWER = 32'd16257;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  typedef enum logic [1:0] {
    FMT_AVR    = 2'd0,
    FMT_AVR_TS = 2'd1,
    FMT_BEAST  = 2'd2
  } fmt_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_TSHEX,
    ST_HI,
    ST_LO,
    ST_SEMI,
    ST_NL,
    ST_ESC,
    ST_TYPE,
    ST_TSBIN,
    ST_LEVEL,
    ST_DATA
  } state_e;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              first;
    logic              last;
    fmt_e              fmt;
    logic [7:0]        type_byte;
    logic [TS_W-1:0]   timestamp;
    logic [SQRT_W-1:0] power;
    logic              power_sat;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [SQRT_W-1:0] value;
  } sqrt_req_t;

endpackage

`default_nettype wire

// ----- design/msfof_front.sv -----
// Input side: holds the format register, accepts frame bytes and classifies them
// into queue entries. Depends on msfof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msfof_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  // [7:0] data_byte, [11:8] frame_len, [59:12] timestamp, [91:60] signal_power
  input  wire logic [95:0]        s_axis_tdata,
  // [0] first_byte
  input  wire logic               s_axis_tuser,
  input  wire logic               s_axis_tlast,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_wdata_i,
  input  wire logic               fifo_ready_i,
  output logic                    push_o,
  output msfof_pkg::item_t        item_o
);

  logic [1:0]  fmt_q;
  logic [3:0]  frame_len;
  logic [31:0] power;
  msfof_pkg::fmt_e fmt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= 2'd0;
    end else if (cfg_we_i) begin
      fmt_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    case (fmt_q)
      msfof_pkg::FMT_AVR:    fmt = msfof_pkg::FMT_AVR;
      msfof_pkg::FMT_AVR_TS: fmt = msfof_pkg::FMT_AVR_TS;
      default:               fmt = msfof_pkg::FMT_BEAST;
    endcase
  end

  assign frame_len = s_axis_tdata[11:8];
  assign power     = s_axis_tdata[91:60];

  always_comb begin
    item_o.data_byte = s_axis_tdata[7:0];
    item_o.first     = s_axis_tuser;
    item_o.last      = s_axis_tlast;
    item_o.fmt       = fmt;
    item_o.type_byte = (frame_len == msfof_pkg::SHORT_FRAME_LEN) ?
                       msfof_pkg::CHAR_TWO : msfof_pkg::CHAR_THREE;
    item_o.timestamp = s_axis_tdata[59:12];
    // powers at or above the threshold round to a root of 128 or more
    item_o.power_sat = (power >= msfof_pkg::SQRT_SAT_POWER);
    item_o.power     = item_o.power_sat ? '0 : power[msfof_pkg::SQRT_W-1:0];
  end

  assign s_axis_tready = fifo_ready_i;
  assign push_o        = s_axis_tvalid & fifo_ready_i;

endmodule

`default_nettype wire

// ----- design/msfof_fifo.sv -----
// Short queue of classified items between the input side and the byte sequencer.
// Depends on msfof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msfof_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  msfof_pkg::item_t        item_i,
  output logic                    ready_o,
  input  wire logic               pop_i,
  output msfof_pkg::item_t        head_o,
  output logic                    valid_o
);

  msfof_pkg::item_t                 mem_q [msfof_pkg::FIFO_DEPTH];
  logic [msfof_pkg::FIFO_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [msfof_pkg::FIFO_AW:0]      count_q, count_d;

  assign ready_o = (count_q != (msfof_pkg::FIFO_AW+1)'(msfof_pkg::FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q != (msfof_pkg::FIFO_AW+1)'(msfof_pkg::FIFO_DEPTH))
    else $error("transfer pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ----- design/msfof_isqrt.sv -----
// Bit-pair square root of the clipped signal power, one step per cycle, rounded.
// Depends on msfof_pkg.
`timescale 1ns / 1ps
`default_nettype none

module msfof_isqrt (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  msfof_pkg::sqrt_req_t               req_i,
  output logic [msfof_pkg::ROOT_W-1:0]       root_o,
  output logic                               busy_o
);

  logic [msfof_pkg::SQRT_W-1:0]     rem_q, rem_d, res_q, res_d;
  logic [msfof_pkg::SQRT_BIT_W-1:0] bit_q, bit_d;
  logic [msfof_pkg::SQRT_W:0]       trial;

  assign trial = {1'b0, res_q} + (msfof_pkg::SQRT_W+1)'(bit_q);

  always_comb begin
    rem_d = rem_q;
    res_d = res_q;
    bit_d = bit_q;
    if (req_i.start) begin
      rem_d = req_i.value;
      res_d = '0;
      bit_d = {1'b1, {(msfof_pkg::SQRT_BIT_W-1){1'b0}}};
    end else if (bit_q != '0) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d = msfof_pkg::SQRT_W'({1'b0, rem_q} - trial);
        res_d = (res_q >> 1) + msfof_pkg::SQRT_W'(bit_q);
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else begin
      bit_q <= bit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
  end

  // round up when the remainder exceeds the root
  assign root_o = res_q[msfof_pkg::ROOT_W-1:0] + msfof_pkg::ROOT_W'(rem_q > res_q);
  assign busy_o = (bit_q != '0);

endmodule

`default_nettype wire

// ----- design/msfof_back.sv -----
// Byte sequencer: walks each queued item through its header, body and trailer
// bytes into the output register. Depends on msfof_pkg and msfof_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module msfof_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  msfof_pkg::item_t        head_i,
  input  wire logic               head_valid_i,
  output logic                    pop_o,
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]              m_axis_tdata,
  output logic                    m_axis_tlast,
  // [0] message_end
  output logic                    m_axis_tuser
);

  msfof_pkg::state_e state_q, state_d, state_n;
  msfof_pkg::item_t  cur_q, cur_d;
  logic [msfof_pkg::TS_W-1:0]  ts_q, ts_d, ts_n;
  logic [msfof_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_n;
  logic                        dup_q, dup_d, dup_n;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  out_byte_q, out_byte_d;
  logic                        out_last_q, out_last_d, out_end_q, out_end_d;
  logic [7:0]                  byte_val, level;
  logic                        fin, adv, step_done, esc_hit;
  logic [msfof_pkg::ROOT_W-1:0] root;
  logic                        sqrt_busy;
  msfof_pkg::sqrt_req_t        sqrt_req;
  msfof_pkg::state_e           start_state;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? msfof_pkg::CHAR_ZERO + wide : msfof_pkg::CHAR_A_OFS + wide;
  endfunction

  msfof_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sqrt_req),
    .root_o (root),
    .busy_o (sqrt_busy)
  );

  assign level = cur_q.power_sat ? msfof_pkg::LEVEL_MAX : {root, 1'b0};

  always_comb begin
    byte_val = '0;
    fin      = 1'b0;
    state_n  = state_q;
    cnt_n    = cnt_q;
    ts_n     = ts_q;
    dup_n    = 1'b0;
    esc_hit  = 1'b0;
    case (state_q)
      msfof_pkg::ST_HDR: begin
        cnt_n = '0;
        if (cur_q.fmt == msfof_pkg::FMT_AVR_TS) begin
          byte_val = msfof_pkg::CHAR_AT;
          state_n  = msfof_pkg::ST_TSHEX;
        end else begin
          byte_val = msfof_pkg::CHAR_STAR;
          state_n  = msfof_pkg::ST_HI;
        end
      end
      msfof_pkg::ST_TSHEX: begin
        byte_val = hex_char(ts_q[msfof_pkg::TS_W-1 -: 4]);
        ts_n     = ts_q << 4;
        cnt_n    = cnt_q + 1'b1;
        if (cnt_q == msfof_pkg::CNT_W'(msfof_pkg::TS_NIBBLES-1)) begin
          state_n = msfof_pkg::ST_HI;
        end
      end
      msfof_pkg::ST_HI: begin
        byte_val = hex_char(cur_q.data_byte[7:4]);
        state_n  = msfof_pkg::ST_LO;
      end
      msfof_pkg::ST_LO: begin
        byte_val = hex_char(cur_q.data_byte[3:0]);
        if (cur_q.last) begin
          state_n = msfof_pkg::ST_SEMI;
        end else begin
          fin = 1'b1;
        end
      end
      msfof_pkg::ST_SEMI: begin
        byte_val = msfof_pkg::CHAR_SEMI;
        state_n  = msfof_pkg::ST_NL;
      end
      msfof_pkg::ST_NL: begin
        byte_val = msfof_pkg::CHAR_NL;
        fin      = 1'b1;
      end
      msfof_pkg::ST_ESC: begin
        byte_val = msfof_pkg::ESC_BYTE;
        state_n  = msfof_pkg::ST_TYPE;
      end
      msfof_pkg::ST_TYPE: begin
        byte_val = cur_q.type_byte;
        cnt_n    = '0;
        state_n  = msfof_pkg::ST_TSBIN;
      end
      msfof_pkg::ST_TSBIN: begin
        byte_val = ts_q[msfof_pkg::TS_W-1 -: 8];
        esc_hit  = (byte_val == msfof_pkg::ESC_BYTE) && !dup_q;
        if (esc_hit) begin
          dup_n = 1'b1;
        end else begin
          ts_n  = ts_q << 8;
          cnt_n = cnt_q + 1'b1;
          if (cnt_q == msfof_pkg::CNT_W'(msfof_pkg::TS_BYTES-1)) begin
            state_n = msfof_pkg::ST_LEVEL;
          end
        end
      end
      msfof_pkg::ST_LEVEL: begin
        byte_val = level;
        esc_hit  = (byte_val == msfof_pkg::ESC_BYTE) && !dup_q;
        if (esc_hit) begin
          dup_n = 1'b1;
        end else begin
          state_n = msfof_pkg::ST_DATA;
        end
      end
      msfof_pkg::ST_DATA: begin
        byte_val = cur_q.data_byte;
        esc_hit  = (byte_val == msfof_pkg::ESC_BYTE) && !dup_q;
        if (esc_hit) begin
          dup_n = 1'b1;
        end else begin
          fin = 1'b1;
        end
      end
      default: begin
        state_n = msfof_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (head_i.fmt == msfof_pkg::FMT_BEAST) begin
      start_state = head_i.first ? msfof_pkg::ST_ESC : msfof_pkg::ST_DATA;
    end else begin
      start_state = head_i.first ? msfof_pkg::ST_HDR : msfof_pkg::ST_HI;
    end
  end

  assign adv       = (state_q != msfof_pkg::ST_IDLE) && (!out_valid_q || m_axis_tready);
  assign step_done = adv && fin;
  assign pop_o     = head_valid_i && ((state_q == msfof_pkg::ST_IDLE) || step_done);

  assign sqrt_req.start = pop_o;
  assign sqrt_req.value = head_i.power;

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    ts_d    = ts_q;
    cnt_d   = cnt_q;
    dup_d   = dup_q;
    if (adv) begin
      state_d = state_n;
      ts_d    = ts_n;
      cnt_d   = cnt_n;
      dup_d   = dup_n;
    end
    if (step_done) begin
      state_d = msfof_pkg::ST_IDLE;
    end
    if (pop_o) begin
      state_d = start_state;
      cur_d   = head_i;
      ts_d    = head_i.timestamp;
      cnt_d   = '0;
      dup_d   = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_end_d   = out_end_q;
    if (adv) begin
      out_valid_d = 1'b1;
      out_byte_d  = byte_val;
      out_last_d  = fin;
      out_end_d   = fin && cur_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msfof_pkg::ST_IDLE;
      cnt_q       <= '0;
      dup_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      dup_q       <= dup_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    ts_q       <= ts_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_end_q  <= out_end_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_end_q;

`ifndef SYNTHESIS
  a_root_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == msfof_pkg::ST_LEVEL |-> !sqrt_busy)
    else $error("level byte sent before the root settled");

  a_dup_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dup_q |-> state_q == msfof_pkg::ST_TSBIN || state_q == msfof_pkg::ST_LEVEL ||
              state_q == msfof_pkg::ST_DATA)
    else $error("escape repeat pending outside an escaped byte");

  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_end_q |-> out_last_q)
    else $error("message end without end of run");
`endif

endmodule

`default_nettype wire

// ----- design/mode_s_frame_output_formatter.sv -----
// Top level of the Mode S frame output formatter: input side, item queue and
// byte sequencer. Depends on msfof_pkg, msfof_front, msfof_fifo and msfof_back.
//
// Usage:
//   s_axis carries one frame byte per transfer, marked first (tuser) and last
//   (tlast), with frame length, timestamp and signal power beside it.
//   m_axis carries the formatted bytes one per transfer; tlast marks the final
//   byte caused by an input transfer, tuser the final byte of a message.
//   cfg_we_i/cfg_wdata_i write the output format (AVR text, AVR with timestamp,
//   Beast binary); the user must write it only while the block is idle (not enforced).
// Throughput: the sequencer sends one byte per cycle while m_axis accepts them;
//   an item makes 2 bytes per AVR body byte, 1 (2 if escaped) per Beast body
//   byte, plus 1 or 13 header and 2 trailer bytes in AVR, 9 to 16 header bytes in Beast.
//   A 4-entry queue absorbs header bursts so input keeps flowing.
// The level byte comes from a 7-step root unit started when the item leaves
//   the queue; it finishes while the header is still being sent.
// Reset clears the queue, the sequencer and the output register and sets the
//   format to AVR text. When m_axis stalls, the output register holds its byte,
//   the sequencer waits and the queue fills before s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module mode_s_frame_output_formatter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] data_byte, [11:8] frame_len, [59:12] timestamp, [91:60] signal_power
  input  wire logic [95:0] s_axis_tdata,
  // [0] first_byte
  input  wire logic        s_axis_tuser,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] out_byte
  output logic [7:0]       m_axis_tdata,
  // [0] message_end
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_wdata_i
);

  msfof_pkg::item_t item, head;
  logic             push, fifo_ready, pop, head_valid;

  msfof_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fifo_ready_i  (fifo_ready),
    .push_o        (push),
    .item_o        (item)
  );

  msfof_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .ready_o (fifo_ready),
    .pop_i   (pop),
    .head_o  (head),
    .valid_o (head_valid)
  );

  msfof_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .head_valid_i  (head_valid),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

// ----- test/mode_s_frame_output_formatter_test.sv -----
// Self-checking bench for mode_s_frame_output_formatter: AVR text, AVR with
// timestamp and Beast binary framing are predicted per transfer and compared
// byte by byte. Depends on msfof_pkg and the design sources only.
`timescale 1ns / 1ps

module mode_s_frame_output_formatter_test;

  localparam logic [1:0] FMT_BEAST_ALT = 2'd3;
  localparam int         NO_WRITE      = -1;
  localparam int         CYCLE_LIMIT   = 600000;
  localparam int         TAIL_CYCLES   = 20;
  localparam int         HOLD_CYCLES   = 90;

  typedef struct {
    logic [7:0]  data;
    logic        first_b;
    logic        last_b;
    logic [3:0]  flen;
    logic [47:0] ts;
    logic [31:0] pw;
  } frame_byte_t;

  typedef struct {
    logic [7:0] out_byte;
    logic       run_last;
    logic       msg_end;
  } out_byte_t;

  typedef struct {
    int           wr_fmt;
    frame_byte_t  item;
    int           n_typed;
    logic [159:0] typed;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [95:0] s_data = '0;
  logic        s_first = 1'b0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_wdata = '0;

  wire         s_axis_tready;
  wire         m_axis_tvalid;
  wire  [7:0]  m_axis_tdata;
  wire         m_axis_tuser;
  wire         m_axis_tlast;

  mode_s_frame_output_formatter dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_first),
    .s_axis_tlast (s_last),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  out_byte_t pending_bytes[$];
  plan_row_t plan[$];
  logic [1:0] fmt_shadow = msfof_pkg::FMT_AVR;
  int cycle_count = 0;
  int error_count = 0;
  int items_sent = 0;
  int bytes_checked = 0;
  int frames_sent = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  int hold_left = 0;
  int rx_stall = 0;
  bit hold_request = 1'b0;

  initial begin
    forever begin
      #5 clk_i = ~clk_i;
      if (clk_i) cycle_count++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d bytes outstanding", cycle_count,
             pending_bytes.size());
    $display("tb: failure");
    $finish;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(30, 10);
    return $urandom_range(3, 1);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    return (nib < 4'd10) ? msfof_pkg::CHAR_ZERO + 8'(nib) : msfof_pkg::CHAR_A_OFS + 8'(nib);
  endfunction

  // 2 * round(sqrt(pw)), saturated
  function automatic logic [7:0] level_of(logic [31:0] pw);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= {32'd0, pw}) root = trial;
    end
    if ({32'd0, pw} - root * root > root) root = root + 1;
    root = root << 1;
    return (root > 64'd255) ? msfof_pkg::LEVEL_MAX : root[7:0];
  endfunction

  function automatic void queue_bytes(logic [7:0] seq[$], logic last_b);
    out_byte_t ob;
    foreach (seq[k]) begin
      ob.out_byte = seq[k];
      ob.run_last = (k == seq.size() - 1);
      ob.msg_end  = (k == seq.size() - 1) && last_b;
      pending_bytes.push_back(ob);
    end
  endfunction

  function automatic void predict_format(frame_byte_t it);
    logic [7:0] seq[$];
    logic [7:0] b;
    if (fmt_shadow == msfof_pkg::FMT_AVR || fmt_shadow == msfof_pkg::FMT_AVR_TS) begin
      if (it.first_b) begin
        if (fmt_shadow == msfof_pkg::FMT_AVR) begin
          seq.push_back(msfof_pkg::CHAR_STAR);
        end else begin
          seq.push_back(msfof_pkg::CHAR_AT);
          for (int s = 44; s >= 0; s -= 4) seq.push_back(hex_char(it.ts[s +: 4]));
        end
      end
      seq.push_back(hex_char(it.data[7:4]));
      seq.push_back(hex_char(it.data[3:0]));
      if (it.last_b) begin
        seq.push_back(msfof_pkg::CHAR_SEMI);
        seq.push_back(msfof_pkg::CHAR_NL);
      end
    end else begin
      if (it.first_b) begin
        seq.push_back(msfof_pkg::ESC_BYTE);
        seq.push_back((it.flen == msfof_pkg::SHORT_FRAME_LEN) ?
                      msfof_pkg::CHAR_TWO : msfof_pkg::CHAR_THREE);
        for (int s = 40; s >= 0; s -= 8) begin
          b = it.ts[s +: 8];
          seq.push_back(b);
          if (b == msfof_pkg::ESC_BYTE) seq.push_back(b);
        end
        b = level_of(it.pw);
        seq.push_back(b);
        if (b == msfof_pkg::ESC_BYTE) seq.push_back(b);
      end
      seq.push_back(it.data);
      if (it.data == msfof_pkg::ESC_BYTE) seq.push_back(it.data);
    end
    queue_bytes(seq, it.last_b);
  endfunction

  // enter just after a rising edge (or at start); leave just after the transfer
  task automatic send_byte(frame_byte_t it, int n_typed, logic [159:0] typed);
    int gap;
    logic [7:0] seq[$];
    gap = pick_gap(tx_pct);
    @(negedge clk_i);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_data  <= {4'd0, it.pw, it.ts, it.flen, it.data};
    s_first <= it.first_b;
    s_last  <= it.last_b;
    s_valid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (n_typed > 0) begin
      for (int k = 0; k < n_typed; k++) seq.push_back(typed[8 * (n_typed - 1 - k) +: 8]);
      queue_bytes(seq, it.last_b);
    end else begin
      predict_format(it);
    end
  endtask

  task automatic drain_out();
    @(negedge clk_i);
    s_valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_format(logic [1:0] fmt);
    drain_out();
    cfg_wdata <= fmt;
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    fmt_shadow = fmt;
  endtask

  function automatic void add_row(int wr_fmt, logic [7:0] data, logic first_b, logic last_b,
                                  logic [3:0] flen, logic [47:0] ts, logic [31:0] pw,
                                  int n_typed, logic [159:0] typed);
    plan_row_t r;
    r.wr_fmt  = wr_fmt;
    r.item    = '{data, first_b, last_b, flen, ts, pw};
    r.n_typed = n_typed;
    r.typed   = typed;
    plan.push_back(r);
  endfunction

  function automatic logic [7:0] rand_data();
    case ($urandom_range(9))
      0, 1:    return msfof_pkg::ESC_BYTE;
      2:       return 8'h00;
      3:       return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [47:0] rand_ts();
    logic [47:0] ts;
    ts = {16'($urandom), 32'($urandom)};
    if ($urandom_range(3) == 0) ts[8 * $urandom_range(5) +: 8] = msfof_pkg::ESC_BYTE;
    return ts;
  endfunction

  function automatic logic [31:0] rand_power();
    logic [31:0] r;
    r = 32'($urandom_range(65535));
    case ($urandom_range(4))
      0:       return 32'($urandom);
      1:       return 32'($urandom_range(20000));
      2:       return r * r + 32'($urandom_range(2)) * r + 32'($urandom_range(1));
      3:       return 32'($urandom_range(16260, 16250));
      default: return 32'($urandom_range(172, 160));
    endcase
  endfunction

  task automatic run_phase(logic [1:0] fmt, int count, int tx, int rx, bit hold,
                           bit pause_mid);
    int sent;
    int len;
    bit paused;
    frame_byte_t it;
    sent = 0;
    paused = 1'b0;
    write_format(fmt);
    tx_pct = tx;
    rx_pct = rx;
    if (hold) hold_request = 1'b1;
    while (sent < count) begin
      if (pause_mid && !paused && sent >= count / 2) begin
        drain_out();
        paused = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        it = '{rand_data(), 1'($urandom), 1'($urandom), 4'($urandom), rand_ts(),
               rand_power()};
        send_byte(it, 0, '0);
        sent++;
      end else begin
        case ($urandom_range(5))
          0, 1:    len = 7;
          2, 3:    len = 14;
          default: len = $urandom_range(14, 1);
        endcase
        if (len > count - sent) len = count - sent;
        it.flen = 4'(len);
        if ($urandom_range(15) == 0) it.flen = $urandom_range(1) ? 4'd0 : 4'd15;
        it.ts = rand_ts();
        it.pw = rand_power();
        for (int k = 0; k < len; k++) begin
          it.data    = rand_data();
          it.first_b = (k == 0);
          it.last_b  = (k == len - 1);
          send_byte(it, 0, '0);
        end
        frames_sent++;
        sent += len;
      end
    end
  endtask

  // output side: random back-pressure, one long hold on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_ready) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected transfer: out_byte %h run_last %b message_end %b",
                 m_axis_tdata, m_axis_tlast, m_axis_tuser);
          error_count++;
        end else begin
          out_byte_t want;
          want = pending_bytes.pop_front();
          bytes_checked++;
          if (m_axis_tdata !== want.out_byte) begin
            $error("out_byte: expected %h, actual %h", want.out_byte, m_axis_tdata);
            error_count++;
          end
          if (m_axis_tlast !== want.run_last) begin
            $error("run_last: expected %b, actual %b", want.run_last, m_axis_tlast);
            error_count++;
          end
          if (m_axis_tuser !== want.msg_end) begin
            $error("message_end: expected %b, actual %b", want.msg_end, m_axis_tuser);
            error_count++;
          end
        end
      end
      @(negedge clk_i);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left == 0 && rx_stall == 0) rx_stall = pick_gap(rx_pct);
      if (hold_left > 0) begin
        hold_left--;
        m_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  initial begin
    // AVR text straight out of reset
    add_row(NO_WRITE, 8'h00, 1, 0, 4'd14, 48'h0, 32'd0, 3, "*00");
    add_row(NO_WRITE, 8'hff, 0, 0, 4'd14, 48'h0, 32'd0, 2, "FF");
    add_row(NO_WRITE, 8'ha5, 0, 1, 4'd14, 48'h0, 32'd0, 4, "A5;\n");
    add_row(NO_WRITE, 8'h1a, 1, 1, 4'd7, 48'h123456789abc, 32'd5, 5, "*1A;\n");
    // AVR with timestamp
    add_row(msfof_pkg::FMT_AVR_TS, 8'h3c, 1, 0, 4'd14, 48'hffffffffffff, 32'd0, 0, '0);
    add_row(NO_WRITE, 8'h00, 0, 0, 4'd14, 48'h0, 32'd0, 0, '0);
    add_row(NO_WRITE, 8'hff, 0, 1, 4'd14, 48'h0, 32'd0, 0, '0);
    add_row(NO_WRITE, 8'h5a, 1, 1, 4'd7, 48'h0, 32'd0, 17, "@0000000000005A;\n");
    // Beast binary: escapes, level rounding and saturation, type byte
    add_row(msfof_pkg::FMT_BEAST, 8'h00, 1, 0, 4'd7, 48'h0, 32'd0, 10,
            80'h1a32_0000_0000_0000_0000);
    add_row(NO_WRITE, 8'h1a, 1, 1, 4'd14, 48'h1a1a1a1a1a1a, 32'hffffffff, 0, '0);
    add_row(NO_WRITE, 8'h7e, 1, 0, 4'd0, 48'h0123456789ab, 32'd169, 0, '0);
    add_row(NO_WRITE, 8'h01, 1, 0, 4'd15, 48'h800000000001, 32'd16256, 0, '0);
    add_row(NO_WRITE, 8'h02, 1, 0, 4'd1, 48'h7fffffffffff, 32'd16257, 0, '0);
    add_row(NO_WRITE, 8'h1a, 0, 0, 4'd14, 48'h0, 32'd0, 2, 16'h1a1a);
    add_row(NO_WRITE, 8'hff, 0, 1, 4'd14, 48'h0, 32'd0, 1, 8'hff);
    add_row(NO_WRITE, 8'h80, 1, 1, 4'd3, 48'h001a00001a00, 32'd0, 0, '0);
    // format code three behaves as Beast
    add_row(FMT_BEAST_ALT, 8'h1b, 1, 1, 4'd7, 48'h0000ffff0000, 32'd1, 0, '0);
    add_row(NO_WRITE, 8'h1a, 0, 0, 4'd14, 48'h0, 32'd0, 2, 16'h1a1a);
    // back to AVR text: body and trailer only
    add_row(msfof_pkg::FMT_AVR, 8'h9f, 0, 1, 4'd14, 48'h0, 32'd0, 4, "9F;\n");

    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    tx_pct = 20;
    rx_pct = 20;
    foreach (plan[i]) begin
      if (plan[i].wr_fmt != NO_WRITE) write_format(2'(plan[i].wr_fmt));
      send_byte(plan[i].item, plan[i].n_typed, plan[i].typed);
    end

    run_phase(msfof_pkg::FMT_AVR_TS, 33, 0, 0, 1'b0, 1'b0);
    run_phase(msfof_pkg::FMT_BEAST, 33, 0, 25, 1'b1, 1'b0);
    run_phase(msfof_pkg::FMT_AVR, 33, 30, 30, 1'b0, 1'b1);
    run_phase(FMT_BEAST_ALT, 33, 25, 15, 1'b0, 1'b0);
    run_phase(msfof_pkg::FMT_BEAST, 33, 10, 40, 1'b0, 1'b0);
    run_phase(msfof_pkg::FMT_AVR_TS, 33, 35, 20, 1'b1, 1'b0);
    run_phase(msfof_pkg::FMT_AVR, 33, 15, 15, 1'b0, 1'b0);

    drain_out();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("run: %0d bytes in (%0d random frames) across all four format codes,",
             items_sent, frames_sent);
    $display("run: %0d output bytes compared in %0d cycles", bytes_checked, cycle_count);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/msfof_pkg.sv
design/msfof_front.sv
design/msfof_fifo.sv
design/msfof_isqrt.sv
design/msfof_back.sv
design/mode_s_frame_output_formatter.sv
test/mode_s_frame_output_formatter_test.sv
